/* src/a85_pkg.sv */
// a85_pkg: shared types and constants for the ASCII85 stream encoder.
// Used by every module under src; no dependencies.
`default_nettype none

package a85_pkg;

  // character codes
  localparam logic [6:0] CHAR_BANG  = 7'h21;  // digit zero
  localparam logic [6:0] CHAR_Z     = 7'h7A;  // all-zero group
  localparam logic [6:0] CHAR_TILDE = 7'h7E;
  localparam logic [6:0] CHAR_GT    = 7'h3E;

  // x / 85 == (x * RECIP85) >> RECIP_SHIFT, exact for every 32-bit x
  localparam logic [31:0] RECIP85     = 32'hC0C0C0C1;
  localparam int          RECIP_SHIFT = 38;
  localparam int          QUO_W       = 64 - RECIP_SHIFT;

  localparam logic [1:0] LAST_DIV = 2'd3;  // four divisions give five digits

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } a85_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       end_of_run;
  } a85_out_t;

  // one group to encode, as classified by the front end
  typedef struct packed {
    logic [31:0] value;  // zero-padded big-endian group
    logic        zero;   // emit 'z' instead of digits
    logic [2:0]  ndig;   // digits kept, 2..5
    logic        fin;    // append the terminator
  } a85_job_t;

  // converted group, digits most significant first
  typedef struct packed {
    logic [0:4][6:0] dig;
    logic            zero;
    logic [2:0]      ndig;
    logic            fin;
  } a85_digits_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_MUL,
    CV_SUB,
    CV_DONE
  } conv_state_e;

endpackage

`default_nettype wire

/* src/a85_front.sv */
// a85_front: accepts input beats, packs bytes into groups and issues one
// job per complete or final group. Depends on a85_pkg.
`default_nettype none

module a85_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire a85_pkg::a85_in_t   in_data_i,
  output      logic               in_stall_o,
  input  wire logic               full_i,
  output      logic               push_o,
  output      a85_pkg::a85_job_t  job_o
);

  logic [23:0] grp_q, grp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;
  logic        full_grp;
  logic [31:0] packed_v;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;
  assign full_grp   = (cnt_q == 2'd3);
  assign packed_v   = {grp_q, in_data_i.data_byte};
  assign push_o     = accept & (full_grp | in_data_i.final_byte);

  always_comb begin
    job_o.fin  = in_data_i.final_byte;
    job_o.zero = 1'b0;
    case (cnt_q)
      2'd0: begin
        job_o.value = {in_data_i.data_byte, 24'h0};
        job_o.ndig  = 3'd2;
      end
      2'd1: begin
        job_o.value = {grp_q[7:0], in_data_i.data_byte, 16'h0};
        job_o.ndig  = 3'd3;
      end
      2'd2: begin
        job_o.value = {grp_q[15:0], in_data_i.data_byte, 8'h0};
        job_o.ndig  = 3'd4;
      end
      default: begin
        job_o.value = packed_v;
        job_o.ndig  = 3'd5;
        job_o.zero  = (packed_v == 32'h0);
      end
    endcase
  end

  always_comb begin
    grp_d = grp_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (full_grp || in_data_i.final_byte) begin
        grp_d = 24'h0;
        cnt_d = 2'd0;
      end else begin
        grp_d = {grp_q[15:0], in_data_i.data_byte};
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= 24'h0;
      cnt_q <= 2'd0;
    end else begin
      grp_q <= grp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

/* src/a85_fifo.sv */
// a85_fifo: two-entry job queue between the front end and the converter.
// Depends on a85_pkg.
`default_nettype none

module a85_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire a85_pkg::a85_job_t  job_i,
  output      logic               full_o,
  input  wire logic               pop_i,
  output      logic               valid_o,
  output      a85_pkg::a85_job_t  job_o
);

  a85_pkg::a85_job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

endmodule

`default_nettype wire

/* src/a85_conv.sv */
// a85_conv: turns a job into five base-85 digits with one shared
// divide-by-85 unit (reciprocal multiply, then remainder). Depends on a85_pkg.
`default_nettype none

module a85_conv (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  job_valid_i,
  input  wire a85_pkg::a85_job_t     job_i,
  output      logic                  job_pop_o,
  output      logic                  dig_valid_o,
  output      a85_pkg::a85_digits_t  dig_o,
  input  wire logic                  dig_ready_i
);

  a85_pkg::conv_state_e        st_q, st_d;
  a85_pkg::a85_digits_t        rec_q;
  logic [31:0]                 val_q;
  logic [a85_pkg::QUO_W-1:0]   quo_q;
  logic [1:0]                  div_q;
  logic [63:0]                 prod;
  logic [6:0]                  rem;
  logic                        take;
  logic                        hand_off;

  // low seven bits suffice: the true remainder is below 85
  assign prod = 64'(val_q) * 64'(a85_pkg::RECIP85);
  assign rem  = val_q[6:0] - ({quo_q[0], 6'b0} + {quo_q[2:0], 4'b0}
                              + {quo_q[4:0], 2'b0} + quo_q[6:0]);

  // control outputs
  always_comb begin
    hand_off = (st_q == a85_pkg::CV_DONE) & dig_ready_i;
    take     = job_valid_i & ((st_q == a85_pkg::CV_IDLE) | hand_off);
  end

  assign job_pop_o   = take;
  assign dig_valid_o = (st_q == a85_pkg::CV_DONE);
  assign dig_o       = rec_q;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      a85_pkg::CV_IDLE: begin
        if (take) begin
          st_d = job_i.zero ? a85_pkg::CV_DONE : a85_pkg::CV_MUL;
        end
      end
      a85_pkg::CV_MUL: begin
        st_d = a85_pkg::CV_SUB;
      end
      a85_pkg::CV_SUB: begin
        st_d = (div_q == a85_pkg::LAST_DIV) ? a85_pkg::CV_DONE : a85_pkg::CV_MUL;
      end
      a85_pkg::CV_DONE: begin
        if (take) begin
          st_d = job_i.zero ? a85_pkg::CV_DONE : a85_pkg::CV_MUL;
        end else if (hand_off) begin
          st_d = a85_pkg::CV_IDLE;
        end
      end
      default: begin
        st_d = a85_pkg::CV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= a85_pkg::CV_IDLE;
      div_q <= 2'd0;
    end else begin
      st_q <= st_d;
      if (take) begin
        div_q <= 2'd0;
      end else if (st_q == a85_pkg::CV_SUB) begin
        div_q <= div_q + 2'd1;
      end
    end
  end

  // datapath; digits arrive least significant first
  always_ff @(posedge clk_i) begin
    if (take) begin
      val_q      <= job_i.value;
      rec_q.zero <= job_i.zero;
      rec_q.ndig <= job_i.ndig;
      rec_q.fin  <= job_i.fin;
    end else if (st_q == a85_pkg::CV_MUL) begin
      quo_q <= prod[63:a85_pkg::RECIP_SHIFT];
    end else if (st_q == a85_pkg::CV_SUB) begin
      val_q <= 32'(quo_q);
      rec_q.dig[3'd4 - {1'b0, div_q}] <= rem;
      if (div_q == a85_pkg::LAST_DIV) begin
        rec_q.dig[0] <= quo_q[6:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == a85_pkg::CV_SUB |-> rem < 7'd85)
    else $error("remainder out of base-85 range");

  a_top_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == a85_pkg::CV_SUB && div_q == a85_pkg::LAST_DIV) |-> quo_q < 85)
    else $error("leading digit out of base-85 range");

  a_hold_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == a85_pkg::CV_DONE && !dig_ready_i) |=>
      (st_q == a85_pkg::CV_DONE && $stable(rec_q)))
    else $error("converted group changed before hand-off");
`endif

endmodule

`default_nettype wire

/* src/a85_emit.sv */
// a85_emit: walks a converted group out as characters, one per cycle while
// the output is not stalled, through a registered output stage. Depends on a85_pkg.
`default_nettype none

module a85_emit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  dig_valid_i,
  input  wire a85_pkg::a85_digits_t  dig_i,
  output      logic                  dig_ready_o,
  output      logic                  out_valid_o,
  output      a85_pkg::a85_out_t     out_data_o,
  input  wire logic                  out_stall_i
);

  a85_pkg::a85_digits_t rec_q;
  a85_pkg::a85_out_t    out_q, out_d;
  logic       busy_q;
  logic       out_valid_q;
  logic [2:0] pos_q;
  logic [2:0] body;
  logic [2:0] len;
  logic [6:0] dig;
  logic       fire;
  logic       last;
  logic       take;

  assign body = rec_q.zero ? 3'd1 : rec_q.ndig;
  assign len  = body + (rec_q.fin ? 3'd2 : 3'd0);
  assign last = (pos_q == len - 3'd1);
  assign fire = busy_q & (~out_valid_q | ~out_stall_i);
  assign take = dig_valid_i & (~busy_q | (fire & last));

  assign dig_ready_o = take;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    case (pos_q)
      3'd0:    dig = rec_q.dig[0];
      3'd1:    dig = rec_q.dig[1];
      3'd2:    dig = rec_q.dig[2];
      3'd3:    dig = rec_q.dig[3];
      3'd4:    dig = rec_q.dig[4];
      default: dig = 7'd0;
    endcase
  end

  always_comb begin
    out_d.end_of_run = last;
    if (pos_q < body) begin
      out_d.out_char = rec_q.zero ? a85_pkg::CHAR_Z : a85_pkg::CHAR_BANG + dig;
    end else if (pos_q == body) begin
      out_d.out_char = a85_pkg::CHAR_TILDE;
    end else begin
      out_d.out_char = a85_pkg::CHAR_GT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= 3'd0;
    end else begin
      out_valid_q <= fire | (out_valid_q & out_stall_i);
      if (take) begin
        busy_q <= 1'b1;
        pos_q  <= 3'd0;
      end else if (fire) begin
        pos_q <= pos_q + 3'd1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rec_q <= dig_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q < len)
    else $error("character position past end of group");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.out_char >= 7'd33 && out_q.out_char <= 7'd126))
    else $error("emitted character outside printable range");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && busy_q) |-> (fire && last))
    else $error("new group loaded before previous one finished");
`endif

endmodule

`default_nettype wire

/* src/ascii85_stream_encoder.sv */
// ascii85_stream_encoder: top level of the ASCII85 byte-stream encoder.
// Depends on a85_pkg, a85_front, a85_fifo, a85_conv and a85_emit.
`default_nettype none

// Bytes enter one per beat with a last-byte flag and are packed big-endian
// into four-byte groups; each complete group comes out as 'z' (all zero) or
// five base-85 digits, a short final group as its byte count plus one
// digits, and the stream closes with '~' then '>'. end_of_run marks the
// last character caused by an input byte. The input side takes a byte every
// cycle until its two-entry group queue fills; a byte that completes no
// group causes no output. Each group then passes the shared divide-by-85
// unit: four divisions of a multiply and a subtract state each, then a done
// state for hand-off that can take the next group; an all-zero group skips
// the divider. Characters leave one per cycle from a registered output stage
// while the output is not stalled.
module ascii85_stream_encoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire a85_pkg::a85_in_t   in_data_i,
  output      logic               in_stall_o,
  output      logic               out_valid_o,
  output      a85_pkg::a85_out_t  out_data_o,
  input  wire logic               out_stall_i
);

  a85_pkg::a85_job_t    push_job;
  a85_pkg::a85_job_t    head_job;
  a85_pkg::a85_digits_t digits;
  logic push;
  logic full;
  logic pop;
  logic head_valid;
  logic dig_valid;
  logic dig_ready;

  a85_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  a85_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  a85_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .dig_valid_o (dig_valid),
    .dig_o       (digits),
    .dig_ready_i (dig_ready)
  );

  a85_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dig_valid_i (dig_valid),
    .dig_i       (digits),
    .dig_ready_o (dig_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for ascii85_stream_encoder.
// Depends on a85_pkg and the encoder sources under src; reads no files.

module tb_top;
  import a85_pkg::*;

  localparam int          HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int unsigned POW85_4        = 85 * 85 * 85 * 85;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid = 1'b0;
  a85_in_t in_data = '0;
  logic    in_stall;
  logic    out_valid;
  a85_out_t out_data;
  logic    out_stall = 1'b0;

  a85_in_t  tx_bytes[$];        // bytes waiting to be offered
  a85_out_t expected_chars[$];  // characters the encoder still owes

  // predicted encoder state
  logic [23:0] grp_value = '0;
  logic [1:0]  grp_count = '0;

  logic in_beat_taken = 1'b0;
  int   send_gap_pct = 21;
  int   recv_stall_pct = 21;
  int   hold_requested = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  int   errors = 0;
  int   bytes_sent = 0;
  int   chars_checked = 0;
  int   streams_queued = 0;
  int   zero_groups = 0;

  always #10 clk_i = ~clk_i;

  ascii85_stream_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_stall_i (out_stall)
  );

  // Work out the characters one accepted byte causes and queue them.
  task automatic encode_byte(input a85_in_t beat);
    logic [31:0] word;
    logic [6:0]  burst [7];
    int unsigned divisor;
    int          nbytes, ndig, k, j;
    a85_out_t    ch;
    nbytes = grp_count + 1;
    word = {grp_value, beat.data_byte};
    k = 0;
    if (nbytes < 4 && !beat.final_byte) begin
      grp_value = word[23:0];
      grp_count = 2'(nbytes);
      return;
    end
    if (nbytes == 4 && word == 32'd0) begin
      burst[k] = CHAR_Z;
      k = k + 1;
      zero_groups++;
    end else begin
      // zero-pad a short final group and keep byte count plus one digits; a full group keeps five
      ndig = (nbytes == 4) ? 5 : nbytes + 1;
      word = word << (8 * (4 - nbytes));
      divisor = POW85_4;
      for (j = 0; j < ndig; j++) begin
        burst[k] = CHAR_BANG + 7'((word / divisor) % 85);
        k = k + 1;
        divisor = divisor / 85;
      end
    end
    if (beat.final_byte) begin
      burst[k] = CHAR_TILDE;
      burst[k + 1] = CHAR_GT;
      k = k + 2;
    end
    grp_value = '0;
    grp_count = '0;
    for (j = 0; j < k; j++) begin
      ch.out_char = burst[j];
      ch.end_of_run = (j == k - 1);
      expected_chars.push_back(ch);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [6:0] got,
                                 input logic [6:0] want);
    $display("mismatch on char %0d: %s got 0x%02h want 0x%02h",
             chars_checked, what, got, want);
    errors++;
  endtask

  // Monitor: input beats feed the predictor, output beats are checked.
  always @(posedge clk_i) begin
    a85_out_t want;
    in_beat_taken <= rst_ni && in_valid && (in_stall === 1'b0);
    if (rst_ni) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected char", out_data.out_char, 7'd0);
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char)
            report_mismatch("out_char", out_data.out_char, want.out_char);
          if (out_data.end_of_run !== want.end_of_run)
            report_mismatch("end_of_run", 7'(out_data.end_of_run), 7'(want.end_of_run));
        end
        chars_checked++;
      end
      if (in_valid && in_stall === 1'b0) begin
        encode_byte(in_data);
        bytes_sent++;
      end
    end
  end

  // Driver: holds the beat until taken, then offers the next one or idles.
  always @(negedge clk_i) begin
    if (rst_ni && (in_beat_taken || !in_valid)) begin
      if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data <= tx_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_served != hold_requested) begin
      hold_served <= hold_requested;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d chars still owed",
               idle_cycles, expected_chars.size());
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Queue one stream; bytes are right-aligned, first byte most significant.
  task automatic add_stream(input logic [127:0] bytes, input int len);
    a85_in_t b;
    int      k;
    for (k = 0; k < len; k++) begin
      b.data_byte = bytes[8 * (len - 1 - k) +: 8];
      b.final_byte = (k == len - 1);
      tx_bytes.push_back(b);
    end
    streams_queued++;
  endtask

  task automatic add_random_streams(input int budget);
    logic [127:0] bytes;
    logic [7:0]   value;
    int           len, k, pick;
    bit           zero_heavy;
    while (budget > 0) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      if (len > budget) len = budget;
      // some streams are mostly zeros so that full zero groups show up
      zero_heavy = ($urandom_range(0, 3) == 0);
      bytes = '0;
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 15);
        if (zero_heavy) value = (pick == 0) ? 8'($urandom) : 8'h00;
        else if (pick < 2) value = 8'h00;
        else if (pick < 4) value = 8'hFF;
        else value = 8'($urandom);
        bytes = {bytes[119:0], value};
      end
      add_stream(bytes, len);
      budget -= len;
    end
  endtask

  task automatic wait_sent;
    while (tx_bytes.size() != 0 || in_valid) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    add_stream(128'h00, 1);                 // lone zero byte: two digits, never 'z'
    add_stream(128'h0000_0000, 4);          // zero group on the last byte gives 'z'
    add_stream(128'hFFFF_FFFF, 4);          // largest group, seven chars
    add_stream(128'hFF_0080, 3);            // three-byte tail
    add_stream(128'h0000, 2);               // short zero tail stays digits
    add_stream(128'h0000_0000_55, 5);       // 'z' mid-stream, one-byte tail
    add_stream(128'h8000_0001_7F, 5);
    wait_sent();

    add_random_streams(60);
    wait_sent();

    // hold the output off while the sender keeps pushing
    send_gap_pct = 0;
    hold_requested++;
    add_random_streams(40);
    wait_sent();

    // no idling on either side
    recv_stall_pct = 0;
    add_random_streams(35);
    wait_sent();

    send_gap_pct = 21;
    recv_stall_pct = 21;
    add_random_streams(25);
    wait_sent();

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("run covered %0d bytes in %0d streams, %0d zero groups",
             bytes_sent, streams_queued, zero_groups);
    $display("%0d characters checked, %0d mismatches", chars_checked, errors);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
